@@ design/lzsd_pkg.sv @@
// Shared types and constants of the LZSS stream decoder.
// No dependencies; imported by the parser, the result stage and the top level.
`default_nettype none

package lzsd_pkg;

   localparam int HISTORY_DEPTH   = 4096;
   localparam int HIST_AW         = $clog2(HISTORY_DEPTH);
   localparam int COUNT_W         = HIST_AW + 1;
   localparam int LEN_W           = 5;
   localparam int ITEMS_PER_GROUP = 8;
   localparam int GROUP_W         = $clog2(ITEMS_PER_GROUP);

   localparam logic [7:0]       TAG_LEN_MASK  = 8'h0F;
   localparam logic [LEN_W-1:0] MIN_MATCH_RST = 5'd3;
   localparam logic [LEN_W-1:0] MIN_MATCH_LO  = 5'd1;
   localparam logic [LEN_W-1:0] MIN_MATCH_HI  = 5'd16;

   typedef enum logic [1:0] {
      PH_FLAGS,
      PH_ITEM,
      PH_TAG_HIGH
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_BEFORE_START = 2'd1,
      ST_TRUNCATED    = 2'd2
   } status_type;

   // Where the byte of an issued result comes from.
   typedef enum logic [1:0] {
      SRC_LITERAL,
      SRC_HISTORY,
      SRC_FORWARD,
      SRC_ZERO
   } src_type;

   typedef struct packed {
      logic               valid;
      src_type            src;
      logic [7:0]         lit;
      logic               has_byte;
      logic               last;
      status_type         status;
      logic [HIST_AW-1:0] wr_addr;
   } issue_type;

endpackage

`default_nettype wire

@@ design/lzsd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/lzsd_parse.sv @@
// Stream parser and copy sequencer: flags, literals, tags, history read issue.
// Depends on lzsd_pkg.
`default_nettype none

module lzsd_parse
   import lzsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] in_byte
   input  wire logic               req_tlast,
   input  wire logic               csr_we,
   input  wire logic [LEN_W-1:0]   csr_wdata,
   input  wire logic               emit_ready,
   output      issue_type          issue,
   output      logic               ram_re,
   output      logic [HIST_AW-1:0] ram_raddr
);

   phase_type            phase_ff, phase_in;
   logic [7:0]           flag_bits_ff, flag_bits_in;
   logic [GROUP_W-1:0]   flag_count_ff, flag_count_in;
   logic [7:0]           tag_low_ff, tag_low_in;
   logic [HIST_AW-1:0]   wp_ff, wp_in;
   logic [COUNT_W-1:0]   produced_ff, produced_in;
   logic [LEN_W-1:0]     min_match_ff, min_match_in;
   logic [LEN_W-1:0]     remain_ff, remain_in;
   logic [HIST_AW-1:0]   src_ptr_ff, src_ptr_in;
   logic [COUNT_W-1:0]   bad_ff, bad_in;
   logic                 fwd_ff, fwd_in;

   logic                 accept;
   logic                 copy_busy;
   logic                 copy_issue;
   logic [LEN_W-1:0]     mm;
   logic [LEN_W-1:0]     len;
   logic [COUNT_W-1:0]   back_dist;
   logic [COUNT_W:0]     sum;
   logic [COUNT_W-1:0]   produced_sat;

   assign copy_busy  = (remain_ff != '0);
   assign req_tready = !copy_busy && emit_ready;
   assign accept     = req_tvalid && req_tready;
   assign copy_issue = copy_busy && emit_ready;

   always_comb begin
      if (min_match_ff < MIN_MATCH_LO) begin
         mm = MIN_MATCH_LO;
      end else if (min_match_ff > MIN_MATCH_HI) begin
         mm = MIN_MATCH_HI;
      end else begin
         mm = min_match_ff;
      end
      len       = LEN_W'(tag_low_ff & TAG_LEN_MASK) + mm;
      back_dist = {1'b0, req_tdata, tag_low_ff[7:4]} + COUNT_W'(1);
   end

   // Saturating count of bytes produced in this stream; grows by one for a
   // literal and by the copy length for a tag.
   always_comb begin
      if (phase_ff == PH_TAG_HIGH) begin
         sum = {1'b0, produced_ff} + (COUNT_W+1)'(len);
      end else begin
         sum = {1'b0, produced_ff} + (COUNT_W+1)'(1);
      end
      if (sum > (COUNT_W+1)'(HISTORY_DEPTH)) begin
         produced_sat = COUNT_W'(HISTORY_DEPTH);
      end else begin
         produced_sat = sum[COUNT_W-1:0];
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      flag_bits_in  = flag_bits_ff;
      flag_count_in = flag_count_ff;
      tag_low_in    = tag_low_ff;
      wp_in         = wp_ff;
      produced_in   = produced_ff;
      min_match_in  = csr_we ? csr_wdata : min_match_ff;
      remain_in     = remain_ff;
      src_ptr_in    = src_ptr_ff;
      bad_in        = bad_ff;
      fwd_in        = fwd_ff;

      issue.valid    = 1'b0;
      issue.src      = SRC_ZERO;
      issue.lit      = req_tdata;
      issue.has_byte = 1'b1;
      issue.last     = 1'b1;
      issue.status   = ST_OK;
      issue.wr_addr  = wp_ff;

      ram_re    = 1'b0;
      ram_raddr = src_ptr_ff;

      if (copy_issue) begin
         issue.valid = 1'b1;
         issue.last  = (remain_ff == LEN_W'(1));
         if (bad_ff != '0) begin
            issue.src    = SRC_ZERO;
            issue.status = ST_BEFORE_START;
            bad_in       = bad_ff - COUNT_W'(1);
         end else if (fwd_ff) begin
            issue.src = SRC_FORWARD;
         end else begin
            issue.src = SRC_HISTORY;
            ram_re    = 1'b1;
         end
         wp_in      = wp_ff + HIST_AW'(1);
         src_ptr_in = src_ptr_ff + HIST_AW'(1);
         remain_in  = remain_ff - LEN_W'(1);
      end

      if (accept) begin
         unique case (phase_ff)
            PH_FLAGS: begin
               flag_bits_in  = req_tdata;
               flag_count_in = '0;
               phase_in      = PH_ITEM;
            end
            PH_ITEM: begin
               if (!flag_bits_ff[flag_count_ff]) begin
                  issue.valid = 1'b1;
                  issue.src   = SRC_LITERAL;
                  wp_in       = wp_ff + HIST_AW'(1);
                  produced_in = produced_sat;
                  if (flag_count_ff == GROUP_W'(ITEMS_PER_GROUP - 1)) begin
                     flag_count_in = '0;
                     phase_in      = PH_FLAGS;
                  end else begin
                     flag_count_in = flag_count_ff + GROUP_W'(1);
                  end
               end else begin
                  tag_low_in = req_tdata;
                  phase_in   = PH_TAG_HIGH;
                  if (req_tlast) begin
                     issue.valid    = 1'b1;
                     issue.src      = SRC_ZERO;
                     issue.has_byte = 1'b0;
                     issue.status   = ST_TRUNCATED;
                  end
               end
            end
            PH_TAG_HIGH: begin
               remain_in   = len;
               src_ptr_in  = wp_ff - back_dist[HIST_AW-1:0];
               bad_in      = (back_dist > produced_ff) ? (back_dist - produced_ff) : '0;
               fwd_in      = (back_dist == COUNT_W'(1));
               produced_in = produced_sat;
               if (flag_count_ff == GROUP_W'(ITEMS_PER_GROUP - 1)) begin
                  flag_count_in = '0;
                  phase_in      = PH_FLAGS;
               end else begin
                  flag_count_in = flag_count_ff + GROUP_W'(1);
                  phase_in      = PH_ITEM;
               end
            end
            default: begin
               phase_in = PH_FLAGS;
            end
         endcase
         if (req_tlast) begin
            phase_in      = PH_FLAGS;
            flag_bits_in  = '0;
            flag_count_in = '0;
            tag_low_in    = '0;
            produced_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FLAGS;
         flag_bits_ff  <= '0;
         flag_count_ff <= '0;
         tag_low_ff    <= '0;
         wp_ff         <= '0;
         produced_ff   <= '0;
         min_match_ff  <= MIN_MATCH_RST;
         remain_ff     <= '0;
         bad_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         flag_count_ff <= flag_count_in;
         tag_low_ff    <= tag_low_in;
         wp_ff         <= wp_in;
         produced_ff   <= produced_in;
         min_match_ff  <= min_match_in;
         remain_ff     <= remain_in;
         bad_ff        <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ptr_ff <= src_ptr_in;
      fwd_ff     <= fwd_in;
   end

endmodule

`default_nettype wire

@@ design/lzsd_emit.sv @@
// Result stage: picks the byte, writes it back to history, drives the output beat.
// Depends on lzsd_pkg.
`default_nettype none

module lzsd_emit
   import lzsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire issue_type          issue,
   output      logic               emit_ready,
   input  wire logic [7:0]         ram_rdata,
   output      logic               ram_we,
   output      logic [HIST_AW-1:0] ram_waddr,
   output      logic [7:0]         ram_wdata,
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [7:0]         rsp_tdata,   // [7:0] out_byte
   output      logic [2:0]         rsp_tuser,   // [0] has_byte, [2:1] status
   output      logic               rsp_tlast
);

   issue_type  s1_ff, s1_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_has_ff, out_has_in;
   logic       out_last_ff, out_last_in;
   status_type out_status_ff, out_status_in;
   logic [7:0] last_byte_ff, last_byte_in;

   logic       out_free;
   logic       advance;
   logic [7:0] value;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = s1_ff.valid && out_free;
   assign emit_ready = !s1_ff.valid || out_free;

   // Distance one can read a byte whose RAM write has not yet landed, so take it from
   // the last-byte register instead of the RAM.
   always_comb begin
      unique case (s1_ff.src)
         SRC_LITERAL: value = s1_ff.lit;
         SRC_HISTORY: value = ram_rdata;
         SRC_FORWARD: value = last_byte_ff;
         SRC_ZERO:    value = '0;
         default:     value = '0;
      endcase
   end

   always_comb begin
      s1_in         = s1_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_has_in    = out_has_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      last_byte_in  = last_byte_ff;
      ram_we        = 1'b0;
      ram_waddr     = s1_ff.wr_addr;
      ram_wdata     = value;

      if (advance) begin
         out_valid_in  = 1'b1;
         out_byte_in   = value;
         out_has_in    = s1_ff.has_byte;
         out_last_in   = s1_ff.last;
         out_status_in = s1_ff.status;
         s1_in.valid   = 1'b0;
         if (s1_ff.has_byte) begin
            ram_we       = 1'b1;
            last_byte_in = value;
         end
      end
      if (emit_ready && issue.valid) begin
         s1_in = issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid  <= s1_in.valid;
         out_valid_ff <= out_valid_in;
      end
      s1_ff.src      <= s1_in.src;
      s1_ff.lit      <= s1_in.lit;
      s1_ff.has_byte <= s1_in.has_byte;
      s1_ff.last     <= s1_in.last;
      s1_ff.status   <= s1_in.status;
      s1_ff.wr_addr  <= s1_in.wr_addr;
      out_byte_ff    <= out_byte_in;
      out_has_ff     <= out_has_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
      last_byte_ff   <= last_byte_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_status_ff, out_has_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

@@ design/lzss_stream_decoder.sv @@
// LZSS stream decoder, 12-bit distance and 4-bit length tags, 4096-byte history.
// A literal beat passes the issue register and the output register to rsp; copy
// bytes also wait on the copy counter. One input beat per cycle for flags and
// literals without back-pressure on rsp; a tag's second byte holds req_tready low for
// its copy length (clamped min_match plus 0..15), at most one history read each.
// Synchronous reset clears the parser, the write pointer and handshake state.
`default_nettype none

module lzss_stream_decoder
   import lzsd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // Compressed stream in.
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [7:0]       req_tdata,   // [7:0] in_byte
   input  wire logic             req_tlast,   // last_in
   // Decoded results out.
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output      logic [2:0]       rsp_tuser,   // [0] has_byte, [2:1] status
   output      logic             rsp_tlast,   // last_of_run
   // min_match register.
   input  wire logic             csr_we,
   input  wire logic [LEN_W-1:0] csr_wdata
);

   // The history RAM is not swept at reset: a copy only reads an entry when
   // its distance is within the bytes produced in the current stream, and all
   // of those were written since reset, so the unswept contents never show.

   issue_type          issue;
   logic               emit_ready;
   logic               ram_re;
   logic [HIST_AW-1:0] ram_raddr;
   logic [7:0]         ram_rdata;
   logic               ram_we;
   logic [HIST_AW-1:0] ram_waddr;
   logic [7:0]         ram_wdata;

   // Parse flags and tags; step through copy runs one byte per cycle while the
   // result stage takes them, and issue the history reads.
   lzsd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .emit_ready (emit_ready),
      .issue      (issue),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr)
   );

   // History ring: one write and one read per cycle, with registered read data.
   lzsd_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Resolve each byte, write it back to the ring and hold it in the output
   // register until the sink takes the beat.
   lzsd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .emit_ready (emit_ready),
      .ram_rdata  (ram_rdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
